// ===== rtl/core/vec3_arithmetic_unit_defines.svh =====
// Assertion helpers for the vector unit
`ifndef VEC3_ARITHMETIC_UNIT_DEFINES_SVH
`define VEC3_ARITHMETIC_UNIT_DEFINES_SVH

`define VAU_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define VAU_ASSERT_NEVER(lbl, cond, msg) \
  `VAU_ASSERT_CLK(lbl, !(cond), msg)

`endif

// ===== rtl/core/vau_pkg.sv =====
package vau_pkg;

  localparam int WORD_BITS   = 32;
  localparam int FRAC_BITS   = 16;
  localparam int LANES       = 3;
  localparam int PROD_BITS   = 2 * WORD_BITS;
  localparam int EXT_BITS    = PROD_BITS + 1;
  localparam int NUM_BITS    = WORD_BITS + FRAC_BITS;
  localparam int RAD_BITS    = 2 * WORD_BITS;
  localparam int ROOT_BITS   = WORD_BITS;
  localparam int REM_BITS    = ROOT_BITS + 2;
  localparam int SQRT_STAGES = ROOT_BITS;
  localparam int DIV_STAGES  = NUM_BITS;

  localparam int IDX_SUM     = 2;
  localparam int IDX_ROOT    = IDX_SUM + SQRT_STAGES;
  localparam int IDX_DEN     = IDX_ROOT + 1;
  localparam int IDX_LAST    = IDX_DEN + DIV_STAGES;
  localparam int META_DEPTH  = IDX_LAST + 1;
  localparam int LATENCY     = META_DEPTH + 1;

  typedef enum logic [2:0] {
    MODE_ADD   = 3'd0,
    MODE_SUB   = 3'd1,
    MODE_SCALE = 3'd2,
    MODE_DIV   = 3'd3,
    MODE_CROSS = 3'd4,
    MODE_LEN   = 3'd5,
    MODE_NORM  = 3'd6
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_SAT = 2'd1,
    ST_DZ  = 2'd2
  } status_e;

  typedef struct packed {
    logic [WORD_BITS-1:0] val;
    logic                 sat;
  } clamp_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] r;
    logic                 sat;
    logic [PROD_BITS-1:0] sq;
  } lane_res_t;

  typedef struct packed {
    mode_e                          mode;
    logic [LANES-1:0][WORD_BITS-1:0] a;
    logic [WORD_BITS-1:0]            s;
    logic [LANES-1:0][WORD_BITS-1:0] r;
    logic                            sat;
    logic [ROOT_BITS-1:0]            len;
    logic                            dz;
  } meta_t;

  function automatic clamp_t sat_word(input logic signed [EXT_BITS-1:0] v);
    logic signed [EXT_BITS-1:0] hi;
    logic signed [EXT_BITS-1:0] lo;
    clamp_t res;
    hi = (EXT_BITS'(1) << (WORD_BITS - 1)) - EXT_BITS'(1);
    lo = -hi - EXT_BITS'(1);
    if (v > hi) begin
      res.val = hi[WORD_BITS-1:0];
      res.sat = 1'b1;
    end else if (v < lo) begin
      res.val = lo[WORD_BITS-1:0];
      res.sat = 1'b1;
    end else begin
      res.val = v[WORD_BITS-1:0];
      res.sat = 1'b0;
    end
    return res;
  endfunction

  function automatic logic [WORD_BITS-1:0] abs_word(input logic [WORD_BITS-1:0] v);
    return v[WORD_BITS-1] ? (~v + WORD_BITS'(1)) : v;
  endfunction

endpackage

// ===== rtl/core/vau_lane.sv =====
module vau_lane import vau_pkg::*; (
  input  logic                 clk_i,
  input  mode_e                mode_i,
  input  logic [WORD_BITS-1:0] a_i,
  input  logic [WORD_BITS-1:0] a_j_i,
  input  logic [WORD_BITS-1:0] a_k_i,
  input  logic [WORD_BITS-1:0] b_i,
  input  logic [WORD_BITS-1:0] b_j_i,
  input  logic [WORD_BITS-1:0] b_k_i,
  input  logic [WORD_BITS-1:0] s_i,
  output lane_res_t            res_o
);

  logic [WORD_BITS-1:0]        op_x, op_y;
  logic signed [PROD_BITS-1:0] m0_q, m1_q;
  logic signed [WORD_BITS:0]   as_q;
  mode_e                       mode_q;
  logic signed [EXT_BITS-1:0]  diff, scaled, wide;
  clamp_t                      cl;
  lane_res_t                   res_d, res_q;

  always_comb begin
    unique case (mode_i)
      MODE_SCALE: begin
        op_x = a_i;
        op_y = s_i;
      end
      MODE_LEN, MODE_NORM: begin
        op_x = a_i;
        op_y = a_i;
      end
      default: begin
        op_x = a_j_i;
        op_y = b_k_i;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    m0_q   <= $signed(op_x) * $signed(op_y);
    m1_q   <= $signed(a_k_i) * $signed(b_j_i);
    as_q   <= (mode_i == MODE_SUB)
              ? ($signed({a_i[WORD_BITS-1], a_i}) - $signed({b_i[WORD_BITS-1], b_i}))
              : ($signed({a_i[WORD_BITS-1], a_i}) + $signed({b_i[WORD_BITS-1], b_i}));
    mode_q <= mode_i;
  end

  always_comb begin
    diff   = $signed({m0_q[PROD_BITS-1], m0_q}) - $signed({m1_q[PROD_BITS-1], m1_q});
    scaled = $signed({m0_q[PROD_BITS-1], m0_q}) >>> FRAC_BITS;
    unique case (mode_q)
      MODE_SCALE: wide = scaled;
      MODE_CROSS: wide = diff >>> FRAC_BITS;
      default:    wide = EXT_BITS'(as_q);
    endcase
    cl        = sat_word(wide);
    res_d.r   = cl.val;
    res_d.sat = cl.sat;
    res_d.sq  = m0_q;
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

// ===== rtl/core/vau_sqrt.sv =====
module vau_sqrt import vau_pkg::*; (
  input  logic                 clk_i,
  input  logic [RAD_BITS-1:0]  rad_i,
  output logic [ROOT_BITS-1:0] root_o
);

  logic [SQRT_STAGES-1:0][RAD_BITS-1:0]  rad_q, rad_d;
  logic [SQRT_STAGES-1:0][REM_BITS-1:0]  rem_q, rem_d;
  logic [SQRT_STAGES-1:0][ROOT_BITS-1:0] root_q, root_d;

  always_comb begin
    logic [RAD_BITS-1:0]  rad_in;
    logic [REM_BITS-1:0]  rem_in;
    logic [ROOT_BITS-1:0] root_in;
    logic [REM_BITS+1:0]  tmp, trial;
    for (int k = 0; k < SQRT_STAGES; k++) begin
      if (k == 0) begin
        rad_in  = rad_i;
        rem_in  = '0;
        root_in = '0;
      end else begin
        rad_in  = rad_q[k-1];
        rem_in  = rem_q[k-1];
        root_in = root_q[k-1];
      end
      tmp      = {rem_in, rad_in[RAD_BITS-1 -: 2]};
      trial    = (REM_BITS + 2)'({root_in, 2'b01});
      rad_d[k] = {rad_in[RAD_BITS-3:0], 2'b00};
      if (tmp >= trial) begin
        rem_d[k]  = REM_BITS'(tmp - trial);
        root_d[k] = {root_in[ROOT_BITS-2:0], 1'b1};
      end else begin
        rem_d[k]  = tmp[REM_BITS-1:0];
        root_d[k] = {root_in[ROOT_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign root_o = root_q[SQRT_STAGES-1];

endmodule

// ===== rtl/core/vau_div.sv =====
module vau_div import vau_pkg::*; (
  input  logic                 clk_i,
  input  logic [NUM_BITS-1:0]  num_i,
  input  logic [WORD_BITS-1:0] den_i,
  output logic [NUM_BITS-1:0]  quot_o
);

  logic [DIV_STAGES-1:0][NUM_BITS-1:0]  nq_q, nq_d;
  logic [DIV_STAGES-1:0][WORD_BITS-1:0] rem_q, rem_d;
  logic [DIV_STAGES-1:0][WORD_BITS-1:0] den_q, den_d;

  always_comb begin
    logic [NUM_BITS-1:0]  nq_in;
    logic [WORD_BITS-1:0] rem_in;
    logic [WORD_BITS-1:0] den_in;
    logic [WORD_BITS:0]   tmp;
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (k == 0) begin
        nq_in  = num_i;
        rem_in = '0;
        den_in = den_i;
      end else begin
        nq_in  = nq_q[k-1];
        rem_in = rem_q[k-1];
        den_in = den_q[k-1];
      end
      tmp      = {rem_in, nq_in[NUM_BITS-1]};
      den_d[k] = den_in;
      if (tmp >= {1'b0, den_in}) begin
        rem_d[k] = WORD_BITS'(tmp - {1'b0, den_in});
        nq_d[k]  = {nq_in[NUM_BITS-2:0], 1'b1};
      end else begin
        rem_d[k] = tmp[WORD_BITS-1:0];
        nq_d[k]  = {nq_in[NUM_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    nq_q  <= nq_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign quot_o = nq_q[DIV_STAGES-1];

endmodule

// ===== rtl/core/vec3_arithmetic_unit.sv =====
// An accepted item strobes done_o once its result has passed the lane, sum, square-root, divider and output registers.
// Throughput: one item per cycle, busy stays low; the receiver cannot stall.
// Depth is set by the 32-stage square-root pipe and the 48-stage divider pipes.
// Reset clears the valid chain and done_o; items in flight are dropped.
module vec3_arithmetic_unit import vau_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [2:0]           mode_i,
  input  logic [WORD_BITS-1:0] a_x_i,
  input  logic [WORD_BITS-1:0] a_y_i,
  input  logic [WORD_BITS-1:0] a_z_i,
  input  logic [WORD_BITS-1:0] b_x_i,
  input  logic [WORD_BITS-1:0] b_y_i,
  input  logic [WORD_BITS-1:0] b_z_i,
  input  logic [WORD_BITS-1:0] scalar_i,
  output logic                 done_o,
  output logic [WORD_BITS-1:0] r_x_o,
  output logic [WORD_BITS-1:0] r_y_o,
  output logic [WORD_BITS-1:0] r_z_o,
  output logic [WORD_BITS-1:0] magnitude_o,
  output logic [1:0]           status_o
);

  logic [LANES-1:0][WORD_BITS-1:0] a_in, b_in;
  lane_res_t [LANES-1:0]           lane_res;
  meta_t [META_DEPTH-1:0]          meta_q, meta_d;
  logic [META_DEPTH-1:0]           vld_q;
  logic [RAD_BITS-1:0]             sum_q;
  logic [ROOT_BITS-1:0]            root;
  logic [WORD_BITS-1:0]            den_d, den_q;
  logic [LANES-1:0][NUM_BITS-1:0]  num_q, quot;
  logic                            dz_d;
  logic [LANES-1:0][WORD_BITS-1:0] r_d, r_q;
  logic [WORD_BITS-1:0]            mag_d, mag_q;
  status_e                         st_d, st_q;
  logic                            done_q;

  assign busy = 1'b0;

  assign a_in = {a_z_i, a_y_i, a_x_i};
  assign b_in = {b_z_i, b_y_i, b_x_i};

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    vau_lane u_lane (
      .clk_i  (clk_i),
      .mode_i (mode_e'(mode_i)),
      .a_i    (a_in[i]),
      .a_j_i  (a_in[(i + 1) % LANES]),
      .a_k_i  (a_in[(i + 2) % LANES]),
      .b_i    (b_in[i]),
      .b_j_i  (b_in[(i + 1) % LANES]),
      .b_k_i  (b_in[(i + 2) % LANES]),
      .s_i    (scalar_i),
      .res_o  (lane_res[i])
    );
  end

  always_ff @(posedge clk_i) begin
    sum_q <= lane_res[0].sq + lane_res[1].sq + lane_res[2].sq;
  end

  vau_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rad_i  (sum_q),
    .root_o (root)
  );

  always_comb begin
    meta_d[0]      = '0;
    meta_d[0].mode = mode_e'(mode_i);
    meta_d[0].a    = a_in;
    meta_d[0].s    = scalar_i;
    for (int k = 1; k < META_DEPTH; k++) begin
      meta_d[k] = meta_q[k-1];
    end
    for (int i = 0; i < LANES; i++) begin
      meta_d[IDX_SUM].r[i] = lane_res[i].r;
    end
    meta_d[IDX_SUM].sat = lane_res[0].sat | lane_res[1].sat | lane_res[2].sat;

    if (meta_q[IDX_ROOT].mode == MODE_NORM) begin
      den_d = root;
    end else begin
      den_d = abs_word(meta_q[IDX_ROOT].s);
    end
    dz_d = (den_d == '0);
    if (dz_d) begin
      den_d = WORD_BITS'(1);
    end
    meta_d[IDX_DEN].len = root;
    meta_d[IDX_DEN].dz  = dz_d;
  end

  always_ff @(posedge clk_i) begin
    meta_q <= meta_d;
    den_q  <= den_d;
    for (int i = 0; i < LANES; i++) begin
      num_q[i] <= {abs_word(meta_q[IDX_ROOT].a[i]), FRAC_BITS'(0)};
    end
  end

  for (genvar i = 0; i < LANES; i++) begin : g_div
    vau_div u_div (
      .clk_i  (clk_i),
      .num_i  (num_q[i]),
      .den_i  (den_q),
      .quot_o (quot[i])
    );
  end

  always_comb begin
    meta_t                      m;
    logic                       sat, dz, neg;
    logic signed [EXT_BITS-1:0] qx;
    clamp_t                     cl;
    m     = meta_q[IDX_LAST];
    sat   = 1'b0;
    dz    = 1'b0;
    r_d   = '0;
    mag_d = '0;
    for (int i = 0; i < LANES; i++) begin
      neg = m.a[i][WORD_BITS-1] ^ ((m.mode == MODE_DIV) & m.s[WORD_BITS-1]);
      qx  = $signed(EXT_BITS'(quot[i]));
      if (neg) begin
        qx = -qx;
      end
      cl = sat_word(qx);
      unique case (m.mode)
        MODE_ADD, MODE_SUB, MODE_SCALE, MODE_CROSS: begin
          r_d[i] = m.r[i];
        end
        MODE_DIV, MODE_NORM: begin
          if (!m.dz) begin
            r_d[i] = cl.val;
            sat    = sat | cl.sat;
          end
        end
        default: r_d[i] = '0;
      endcase
    end
    unique case (m.mode)
      MODE_ADD, MODE_SUB, MODE_SCALE, MODE_CROSS: sat = m.sat;
      MODE_DIV:  dz = m.dz;
      MODE_LEN:  mag_d = m.len;
      MODE_NORM: begin
        dz    = m.dz;
        mag_d = m.dz ? '0 : m.len;
      end
      default: ;
    endcase
    priority if (dz) begin
      st_d = ST_DZ;
    end else if (sat) begin
      st_d = ST_SAT;
    end else begin
      st_d = ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q   <= r_d;
    mag_q <= mag_d;
    st_q  <= st_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[META_DEPTH-2:0], start & ~busy};
      done_q <= vld_q[META_DEPTH-1];
    end
  end

  assign done_o      = done_q;
  assign r_x_o       = r_q[0];
  assign r_y_o       = r_q[1];
  assign r_z_o       = r_q[2];
  assign magnitude_o = mag_q;
  assign status_o    = st_q;

endmodule

// ===== rtl/core/vau_checker.sv =====
`include "vec3_arithmetic_unit_defines.svh"

module vau_checker import vau_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start,
  input logic                 busy,
  input logic [2:0]           mode_i,
  input logic                 done_o,
  input logic [WORD_BITS-1:0] r_x_o,
  input logic [WORD_BITS-1:0] r_y_o,
  input logic [WORD_BITS-1:0] r_z_o,
  input logic [1:0]           status_o
);

  `VAU_ASSERT_CLK(a_done_follows_transfer, done_o |-> $past(start && !busy, LATENCY), "result without transfer")
  `VAU_ASSERT_CLK(a_dz_zero_vector, (done_o && status_o == ST_DZ) |-> (r_x_o == '0 && r_y_o == '0 && r_z_o == '0), "divide by zero with nonzero vector")
  `VAU_ASSERT_CLK(a_len_zero_vector, (done_o && $past(mode_i, LATENCY) == MODE_LEN) |-> (r_x_o == '0 && r_y_o == '0 && r_z_o == '0 && status_o == ST_OK), "length mode vector or status wrong")
  `VAU_ASSERT_NEVER(a_status_code, done_o && status_o != ST_OK && status_o != ST_SAT && status_o != ST_DZ, "undefined status code")

endmodule

bind vec3_arithmetic_unit vau_checker u_vau_checker (.*);
